// ===== hdl/trss_pkg.sv =====
// Shared types and constants for the transmit retransmission slot scheduler.
// No dependencies.
package trss_pkg;

    localparam int SLOTS       = 8;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int ID_BITS     = 8;
    localparam int HANDLE_BITS = 16;
    localparam int LEN_BITS    = 16;
    localparam int SEQ_BITS    = 8;
    localparam int RETRY_BITS  = 8;
    localparam logic [SEQ_BITS-1:0]   OLDEST_NONE = 8'd255;
    localparam logic [RETRY_BITS-1:0] RETRY_MAX   = 8'd255;

    localparam logic [2:0] OP_ADD       = 3'd0;
    localparam logic [2:0] OP_SERVICE   = 3'd1;
    localparam logic [2:0] OP_FREE_ID   = 3'd2;
    localparam logic [2:0] OP_FREE_IDX  = 3'd3;
    localparam logic [2:0] OP_FREE_ALL  = 3'd4;
    localparam logic [2:0] OP_SYNC      = 3'd5;

    localparam logic [2:0] ST_ADDED     = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_SENT      = 3'd2;
    localparam logic [2:0] ST_NOTHING   = 3'd3;
    localparam logic [2:0] ST_NO_TASK   = 3'd4;
    localparam logic [2:0] ST_DELAY     = 3'd5;
    localparam logic [2:0] ST_FREE_DONE = 3'd6;

    localparam logic [1:0] FR_NONE      = 2'd0;
    localparam logic [1:0] FR_LINK_DONE = 2'd1;
    localparam logic [1:0] FR_SINGLE    = 2'd2;
    localparam logic [1:0] FR_RETRIES   = 2'd3;

    localparam logic [1:0] CFG_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MAX_RETX = 2'd1;
    localparam logic [1:0] CFG_OLDEST   = 2'd2;

    typedef struct packed {
        logic [SEQ_BITS-1:0]    seq;
        logic [RETRY_BITS-1:0]  retries;
        logic [ID_BITS-1:0]     user_id;
        logic [HANDLE_BITS-1:0] handle;
        logic [LEN_BITS-1:0]    length;
        logic                   sent;
        logic                   retx;
        logic                   manual;
    } slot_rec_t;

endpackage

// ===== hdl/tx_retransmit_slot_scheduler.sv =====
// Top level of the transmit retransmission slot scheduler: slot record memory,
// used bits and the sequencer for add, service, free and time sync.
// Depends on trss_pkg.
//
//   channel | handshake            | beat
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | op, now_time, msg_*, mode bits, index, done
//   out     | out_valid / out_stall| status, slot_out, send_*, reason, count
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Add, free by index, free all and sync are decided in the exec state; service is
// too when the table is empty or in delay, else it picks and updates a slot, after a
// scan for the oldest slot when that mode is set; free by id scans every slot.
// Scans walk the single read port of the slot memory, one entry a cycle.
// Reset clears the used bits, counters and output; the memory needs no clear.
// A result waiting on out_stall holds the sequencer; the next beat is taken once
// the result sits in the output register.
module tx_retransmit_slot_scheduler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [2:0]                          op,
    input  logic [31:0]                         now_time,
    input  logic [trss_pkg::HANDLE_BITS-1:0]    msg_handle,
    input  logic [trss_pkg::LEN_BITS-1:0]       msg_length,
    input  logic [trss_pkg::ID_BITS-1:0]        msg_id,
    input  logic                                retransmit,
    input  logic                                manual_clear,
    input  logic [trss_pkg::SLOT_W-1:0]         slot_index,
    input  logic                                transmit_done,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [2:0]                          status,
    output logic [trss_pkg::SLOT_W-1:0]         slot_out,
    output logic [trss_pkg::HANDLE_BITS-1:0]    send_handle,
    output logic [trss_pkg::LEN_BITS-1:0]       send_length,
    output logic [trss_pkg::ID_BITS-1:0]        send_id,
    output logic [1:0]                          free_reason,
    output logic [trss_pkg::CNT_W-1:0]          freed_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);
    import trss_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_MOD   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0] state_reg;

    logic [31:0]           interval_reg;
    logic [RETRY_BITS-1:0] max_retx_reg;
    logic                  oldest_reg;

    logic [SLOTS-1:0]    used_reg;
    logic [SEQ_BITS-1:0] seq_cnt_reg;
    logic [31:0]         last_time_reg;

    // latched input beat
    logic [2:0]             op_reg;
    logic [31:0]            now_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [LEN_BITS-1:0]    length_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic                   retx_reg;
    logic                   manual_reg;
    logic [SLOT_W-1:0]      index_reg;
    logic                   done_reg;

    // scan pipeline
    logic [CNT_W-1:0]    cnt_reg;
    logic                pv_reg;
    logic [SLOT_W-1:0]   pidx_reg;
    logic [SEQ_BITS-1:0] best_reg;
    logic [SLOT_W-1:0]   start_reg;
    logic [SLOT_W-1:0]   sel_reg;

    // pending result
    logic [2:0]             res_status_reg;
    logic [SLOT_W-1:0]      res_slot_reg;
    logic [HANDLE_BITS-1:0] res_handle_reg;
    logic [LEN_BITS-1:0]    res_length_reg;
    logic [ID_BITS-1:0]     res_id_reg;
    logic [1:0]             res_reason_reg;
    logic [CNT_W-1:0]       res_count_reg;

    logic                   out_valid_reg;
    logic [2:0]             out_status_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;
    logic [LEN_BITS-1:0]    out_length_reg;
    logic [ID_BITS-1:0]     out_id_reg;
    logic [1:0]             out_reason_reg;
    logic [CNT_W-1:0]       out_count_reg;

    // slot record memory
    slot_rec_t         mem [SLOTS];
    slot_rec_t         rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    slot_rec_t         mem_wd;

    logic              in_acc;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    logic              pick_found;
    logic [SLOT_W-1:0] pick_idx;
    logic [CNT_W-1:0]  used_pop;
    logic              used_empty;
    logic              sendable;
    logic [RETRY_BITS-1:0] retries_next;
    logic [1:0]        reason_next;
    logic              out_free;

    assign in_acc     = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign used_empty = (used_reg == '0);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (used_reg[i] && (SLOT_W'(i) >= start_reg))
            begin
                pick_found = 1'b1;
                pick_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        used_pop = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            used_pop = used_pop + CNT_W'(used_reg[i]);
        end
    end

    // service decision on the record just read
    always_comb
    begin
        sendable     = !rd_data_reg.sent || rd_data_reg.retx;
        retries_next = rd_data_reg.retries;
        reason_next  = FR_NONE;
        if (sendable)
        begin
            if (rd_data_reg.retries != RETRY_MAX)
            begin
                retries_next = rd_data_reg.retries + 1'b1;
            end
            if (done_reg)
            begin
                reason_next = FR_LINK_DONE;
            end
        end
        if (reason_next == FR_NONE && !rd_data_reg.manual)
        begin
            if (!rd_data_reg.retx)
            begin
                reason_next = FR_SINGLE;
            end
            else if (retries_next > max_retx_reg)
            begin
                reason_next = FR_RETRIES;
            end
        end
    end

    always_comb
    begin
        rd_addr = sel_reg;
        if (state_reg == S_SCAN)
        begin
            rd_addr = cnt_reg[SLOT_W-1:0];
        end
        else if (state_reg == S_PICK)
        begin
            rd_addr = pick_idx;
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = sel_reg;
        mem_wd = rd_data_reg;
        if (state_reg == S_EXEC && op_reg == OP_ADD && free_found)
        begin
            mem_we         = 1'b1;
            mem_wa         = free_idx;
            mem_wd.seq     = used_empty ? '0 : seq_cnt_reg;
            mem_wd.retries = '0;
            mem_wd.user_id = id_reg;
            mem_wd.handle  = handle_reg;
            mem_wd.length  = length_reg;
            mem_wd.sent    = 1'b0;
            mem_wd.retx    = retx_reg;
            mem_wd.manual  = manual_reg;
        end
        else if (state_reg == S_MOD)
        begin
            mem_we         = 1'b1;
            mem_wd.sent    = rd_data_reg.sent || sendable;
            mem_wd.retries = retries_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= '0;
            max_retx_reg <= 8'd3;
            oldest_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_INTERVAL: interval_reg <= cfg_data;
                CFG_MAX_RETX: max_retx_reg <= cfg_data[RETRY_BITS-1:0];
                CFG_OLDEST:   oldest_reg   <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg     <= op;
            now_reg    <= now_time;
            handle_reg <= msg_handle;
            length_reg <= msg_length;
            id_reg     <= msg_id;
            retx_reg   <= retransmit;
            manual_reg <= manual_clear;
            index_reg  <= slot_index;
            done_reg   <= transmit_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            seq_cnt_reg    <= '0;
            last_time_reg  <= '0;
            cnt_reg        <= '0;
            pv_reg         <= 1'b0;
            pidx_reg       <= '0;
            best_reg       <= OLDEST_NONE;
            start_reg      <= '0;
            sel_reg        <= '0;
            res_status_reg <= ST_NO_TASK;
            res_slot_reg   <= '0;
            res_handle_reg <= '0;
            res_length_reg <= '0;
            res_id_reg     <= '0;
            res_reason_reg <= FR_NONE;
            res_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_NO_TASK;
            out_slot_reg   <= '0;
            out_handle_reg <= '0;
            out_length_reg <= '0;
            out_id_reg     <= '0;
            out_reason_reg <= FR_NONE;
            out_count_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != S_FIN)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        res_status_reg <= ST_NO_TASK;
                        res_slot_reg   <= '0;
                        res_handle_reg <= '0;
                        res_length_reg <= '0;
                        res_id_reg     <= '0;
                        res_reason_reg <= FR_NONE;
                        res_count_reg  <= '0;
                        cnt_reg        <= '0;
                        pv_reg         <= 1'b0;
                        best_reg       <= OLDEST_NONE;
                        start_reg      <= '0;
                        state_reg      <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    case (op_reg)
                        OP_ADD:
                        begin
                            state_reg <= S_FIN;
                            if (free_found)
                            begin
                                used_reg[free_idx] <= 1'b1;
                                seq_cnt_reg    <= (used_empty ? '0 : seq_cnt_reg) + 1'b1;
                                res_status_reg <= ST_ADDED;
                                res_slot_reg   <= free_idx;
                            end
                            else
                            begin
                                res_status_reg <= ST_FULL;
                            end
                        end
                        OP_SERVICE:
                        begin
                            if (used_empty)
                            begin
                                res_status_reg <= ST_NO_TASK;
                                state_reg      <= S_FIN;
                            end
                            else if ((now_reg - last_time_reg) < interval_reg)
                            begin
                                res_status_reg <= ST_DELAY;
                                state_reg      <= S_FIN;
                            end
                            else
                            begin
                                last_time_reg <= now_reg;
                                state_reg     <= oldest_reg ? S_SCAN : S_PICK;
                            end
                        end
                        OP_FREE_ID:
                        begin
                            res_status_reg <= ST_FREE_DONE;
                            state_reg      <= S_SCAN;
                        end
                        OP_FREE_IDX:
                        begin
                            res_status_reg <= ST_FREE_DONE;
                            res_slot_reg   <= index_reg;
                            res_count_reg  <= CNT_W'(used_reg[index_reg]);
                            used_reg[index_reg] <= 1'b0;
                            state_reg      <= S_FIN;
                        end
                        OP_FREE_ALL:
                        begin
                            res_status_reg <= ST_FREE_DONE;
                            res_count_reg  <= used_pop;
                            used_reg       <= '0;
                            state_reg      <= S_FIN;
                        end
                        OP_SYNC:
                        begin
                            res_status_reg <= ST_FREE_DONE;
                            last_time_reg  <= now_reg;
                            state_reg      <= S_FIN;
                        end
                        default:
                        begin
                            res_status_reg <= ST_NO_TASK;
                            state_reg      <= S_FIN;
                        end
                    endcase
                end

                S_SCAN:
                begin
                    // issue one read a cycle, judge the entry read in the previous cycle
                    if (cnt_reg != CNT_W'(SLOTS))
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    pv_reg   <= (cnt_reg != CNT_W'(SLOTS));
                    pidx_reg <= cnt_reg[SLOT_W-1:0];
                    if (pv_reg && used_reg[pidx_reg])
                    begin
                        if (op_reg == OP_FREE_ID)
                        begin
                            if (rd_data_reg.user_id == id_reg)
                            begin
                                used_reg[pidx_reg] <= 1'b0;
                                res_count_reg      <= res_count_reg + 1'b1;
                            end
                        end
                        else if (rd_data_reg.seq < best_reg)
                        begin
                            best_reg  <= rd_data_reg.seq;
                            start_reg <= pidx_reg;
                        end
                    end
                    if (cnt_reg == CNT_W'(SLOTS) && !pv_reg)
                    begin
                        state_reg <= (op_reg == OP_FREE_ID) ? S_FIN : S_PICK;
                    end
                end

                S_PICK:
                begin
                    if (pick_found)
                    begin
                        sel_reg      <= pick_idx;
                        res_slot_reg <= pick_idx;
                        state_reg    <= S_MOD;
                    end
                    else
                    begin
                        res_status_reg <= ST_NOTHING;
                        state_reg      <= S_FIN;
                    end
                end

                S_MOD:
                begin
                    res_status_reg <= sendable ? ST_SENT : ST_NOTHING;
                    if (sendable)
                    begin
                        res_handle_reg <= rd_data_reg.handle;
                        res_length_reg <= rd_data_reg.length;
                        res_id_reg     <= rd_data_reg.user_id;
                    end
                    res_reason_reg <= reason_next;
                    if (reason_next != FR_NONE)
                    begin
                        used_reg[sel_reg] <= 1'b0;
                        res_count_reg     <= CNT_W'(1);
                    end
                    state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_slot_reg   <= res_slot_reg;
                        out_handle_reg <= res_handle_reg;
                        out_length_reg <= res_length_reg;
                        out_id_reg     <= res_id_reg;
                        out_reason_reg <= res_reason_reg;
                        out_count_reg  <= res_count_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_out    = out_slot_reg;
    assign send_handle = out_handle_reg;
    assign send_length = out_length_reg;
    assign send_id     = out_id_reg;
    assign free_reason = out_reason_reg;
    assign freed_count = out_count_reg;

    a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not moved to output register");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !mem_we)
        else $error("memory write during scan");

    a_sent_has_reason_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reason_reg != FR_NONE) |-> out_count_reg == CNT_W'(1))
        else $error("freed slot not counted");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_count_reg <= CNT_W'(SLOTS))
        else $error("freed count beyond slot count");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for tx_retransmit_slot_scheduler: a directed table,
// then random phases under several register settings, checked by a predictor.
// Depends on trss_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module testbench;
    import trss_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 40;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [2:0]             op;
        logic [31:0]            now;
        logic [HANDLE_BITS-1:0] handle;
        logic [LEN_BITS-1:0]    length;
        logic [ID_BITS-1:0]     id;
        logic                   retx;
        logic                   manual;
        logic [SLOT_W-1:0]      idx;
        logic                   done;
    } msg_op_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [SLOT_W-1:0]      slot;
        logic [HANDLE_BITS-1:0] handle;
        logic [LEN_BITS-1:0]    length;
        logic [ID_BITS-1:0]     id;
        logic [1:0]             reason;
        logic [CNT_W-1:0]       count;
    } sched_res_t;

    typedef struct {
        msg_op_t    beat;
        bit         typed;
        sched_res_t want;
    } table_row_t;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [2:0] op;
    logic [31:0] now_time;
    logic [HANDLE_BITS-1:0] msg_handle;
    logic [LEN_BITS-1:0] msg_length;
    logic [ID_BITS-1:0] msg_id;
    logic retransmit, manual_clear, transmit_done;
    logic [SLOT_W-1:0] slot_index;
    logic [2:0] status;
    logic [SLOT_W-1:0] slot_out;
    logic [HANDLE_BITS-1:0] send_handle;
    logic [LEN_BITS-1:0] send_length;
    logic [ID_BITS-1:0] send_id;
    logic [1:0] free_reason;
    logic [CNT_W-1:0] freed_count;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    tx_retransmit_slot_scheduler i_dut (.*);

    // predictor state
    logic [31:0]            p_interval;
    logic [7:0]             p_max_retx;
    logic                   p_oldest;
    logic                   s_used [SLOTS];
    logic                   s_sent [SLOTS];
    logic                   s_retx [SLOTS];
    logic                   s_manual [SLOTS];
    logic [SEQ_BITS-1:0]    s_seq [SLOTS];
    logic [RETRY_BITS-1:0]  s_retries [SLOTS];
    logic [ID_BITS-1:0]     s_id [SLOTS];
    logic [HANDLE_BITS-1:0] s_handle [SLOTS];
    logic [LEN_BITS-1:0]    s_length [SLOTS];
    int                     used_cnt;
    logic [SEQ_BITS-1:0]    seq_ctr;
    logic [31:0]            last_send;

    sched_res_t pending_results [$];
    int  errors = 0;
    int  cycles = 0;
    bit  hold_long = 0;
    bit  no_idle = 0;
    logic [31:0] tick = 0;

    function automatic msg_op_t mk_op(logic [2:0] o, logic [31:0] t, logic [15:0] h,
                                      logic [15:0] l, logic [7:0] id, logic rx, logic mc,
                                      logic [2:0] ix, logic dn);
        msg_op_t m;
        m = '{o, t, h, l, id, rx, mc, ix, dn};
        return m;
    endfunction

    function automatic sched_res_t mk_res(logic [2:0] st, logic [2:0] sl, logic [15:0] h,
                                          logic [15:0] l, logic [7:0] id, logic [1:0] rs,
                                          logic [3:0] c);
        sched_res_t r;
        r = '{st, sl, h, l, id, rs, c};
        return r;
    endfunction

    function automatic logic release_slot(int i);
        if (!s_used[i])
            return 1'b0;
        s_used[i] = 0; s_sent[i] = 0; s_retx[i] = 0; s_manual[i] = 0;
        s_seq[i] = '0; s_retries[i] = '0; s_id[i] = '0;
        s_handle[i] = '0; s_length[i] = '0;
        used_cnt--;
        return 1'b1;
    endfunction

    function automatic sched_res_t predict_schedule(msg_op_t m);
        sched_res_t r;
        int i, start, n;
        logic [7:0] best;
        logic fired;
        logic [1:0] why;
        r = '0;
        n = 0;
        case (m.op)
            OP_ADD:
            begin
                if (used_cnt == 0)
                    seq_ctr = '0;
                for (i = 0; i < SLOTS; i++)
                    if (!s_used[i])
                        break;
                if (i >= SLOTS)
                    r.status = ST_FULL;
                else
                begin
                    s_used[i] = 1; s_sent[i] = 0; s_retries[i] = '0;
                    s_retx[i] = m.retx; s_manual[i] = m.manual;
                    s_handle[i] = m.handle; s_length[i] = m.length; s_id[i] = m.id;
                    s_seq[i] = seq_ctr;
                    seq_ctr = seq_ctr + 8'd1;
                    used_cnt++;
                    r.status = ST_ADDED;
                    r.slot = SLOT_W'(i);
                end
            end
            OP_SERVICE:
            begin
                if (used_cnt == 0)
                    r.status = ST_NO_TASK;
                else if (m.now - last_send < p_interval)
                    r.status = ST_DELAY;
                else
                begin
                    last_send = m.now;
                    start = 0;
                    if (p_oldest)
                    begin
                        best = OLDEST_NONE;
                        for (i = 0; i < SLOTS; i++)
                            if (s_used[i] && s_seq[i] < best)
                            begin
                                best = s_seq[i];
                                start = i;
                            end
                    end
                    for (i = start; i < SLOTS; i++)
                        if (s_used[i])
                            break;
                    if (i >= SLOTS)
                        r.status = ST_NOTHING;
                    else
                    begin
                        fired = 0;
                        why = FR_NONE;
                        r.slot = SLOT_W'(i);
                        if (!s_sent[i] || s_retx[i])
                        begin
                            fired = 1;
                            r.handle = s_handle[i];
                            r.length = s_length[i];
                            r.id = s_id[i];
                            s_sent[i] = 1;
                            if (s_retries[i] != RETRY_MAX)
                                s_retries[i]++;
                            if (m.done)
                                why = FR_LINK_DONE;
                        end
                        if (why == FR_NONE && !s_manual[i])
                        begin
                            if (!s_retx[i])
                                why = FR_SINGLE;
                            else if (s_retries[i] > p_max_retx)
                                why = FR_RETRIES;
                        end
                        if (why != FR_NONE)
                        begin
                            r.reason = why;
                            r.count = CNT_W'(release_slot(i));
                        end
                        r.status = fired ? ST_SENT : ST_NOTHING;
                    end
                end
            end
            OP_FREE_ID:
            begin
                for (i = 0; i < SLOTS; i++)
                    if (s_used[i] && s_id[i] == m.id)
                        n += release_slot(i);
                r.status = ST_FREE_DONE;
                r.count = CNT_W'(n);
            end
            OP_FREE_IDX:
            begin
                r.count = CNT_W'(release_slot(m.idx));
                r.status = ST_FREE_DONE;
                r.slot = m.idx;
            end
            OP_FREE_ALL:
            begin
                for (i = 0; i < SLOTS; i++)
                    n += release_slot(i);
                r.status = ST_FREE_DONE;
                r.count = CNT_W'(n);
            end
            OP_SYNC:
            begin
                last_send = m.now;
                r.status = ST_FREE_DONE;
            end
            default:
                r.status = ST_NO_TASK;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic offer_beat(msg_op_t m, bit typed, sched_res_t want);
        int gap;
        sched_res_t r;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        op <= m.op; now_time <= m.now; msg_handle <= m.handle; msg_length <= m.length;
        msg_id <= m.id; retransmit <= m.retx; manual_clear <= m.manual;
        slot_index <= m.idx; transmit_done <= m.done;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        r = predict_schedule(m);
        pending_results.push_back(typed ? want : r);
        // drop the beat while the block is busy with it
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_INTERVAL: p_interval = val;
            CFG_MAX_RETX: p_max_retx = val[7:0];
            default:      p_oldest = val[0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        sched_res_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected beat", status, 0);
            else
            begin
                w = pending_results.pop_front();
                if (status !== w.status)      report_mismatch("status", status, w.status);
                if (slot_out !== w.slot)      report_mismatch("slot_out", slot_out, w.slot);
                if (send_handle !== w.handle) report_mismatch("send_handle", send_handle, w.handle);
                if (send_length !== w.length) report_mismatch("send_length", send_length, w.length);
                if (send_id !== w.id)         report_mismatch("send_id", send_id, w.id);
                if (free_reason !== w.reason) report_mismatch("free_reason", free_reason, w.reason);
                if (freed_count !== w.count)  report_mismatch("freed_count", freed_count, w.count);
            end
        end
    end

    // receiver: per-beat stall, with one long hold-off on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (hold_long)
            begin
                n = HOLD_CYCLES;
                hold_long = 0;
            end
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        table_row_t rows [$];
        msg_op_t m;
        int ph, k, pick;

        rst_n = 0; in_valid = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        op = OP_ADD; now_time = '0; msg_handle = '0; msg_length = '0; msg_id = '0;
        retransmit = 0; manual_clear = 0; slot_index = '0; transmit_done = 0;
        p_interval = '0; p_max_retx = 8'd3; p_oldest = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            s_used[i] = 0; s_sent[i] = 0; s_retx[i] = 0; s_manual[i] = 0;
            s_seq[i] = '0; s_retries[i] = '0; s_id[i] = '0; s_handle[i] = '0; s_length[i] = '0;
        end
        used_cnt = 0; seq_ctr = '0; last_send = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (SETTLE) @(posedge clk);

        rows.push_back('{mk_op(OP_SERVICE, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         mk_res(ST_NO_TASK, 0, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(3'd6, '1, '1, '1, '1, 1, 1, '1, 1), 1,
                         mk_res(ST_NO_TASK, 0, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(3'd7, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                         mk_res(ST_NO_TASK, 0, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(OP_ADD, 0, 16'hFFFF, 16'hFFFF, 8'hFF, 0, 0, 0, 0), 1,
                         mk_res(ST_ADDED, 0, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(OP_ADD, 0, 0, 0, 0, 1, 0, 0, 0), 1,
                         mk_res(ST_ADDED, 1, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(OP_ADD, 0, 16'h1234, 16'h0040, 8'h05, 0, 1, 0, 0), 1,
                         mk_res(ST_ADDED, 2, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(OP_SERVICE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0), 1,
                         mk_res(ST_SENT, 0, 16'hFFFF, 16'hFFFF, 8'hFF, FR_SINGLE, 1)});
        // retransmit slot: resend until the retries pass the limit
        for (k = 0; k < 4; k++)
            rows.push_back('{mk_op(OP_SERVICE, k, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_SERVICE, 9, 0, 0, 0, 0, 0, 0, 1), 0, '0});
        rows.push_back('{mk_op(OP_ADD, 0, 16'hA5A5, 16'h5A5A, 8'h09, 0, 1, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_SERVICE, 20, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_SERVICE, 21, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_FREE_IDX, 0, 0, 0, 0, 0, 0, 3'd7, 0), 1,
                         mk_res(ST_FREE_DONE, 7, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(OP_FREE_ID, 0, 0, 0, 8'h09, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_ADD, 0, 1, 1, 8'h03, 1, 1, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_ADD, 0, 2, 2, 8'h03, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_ADD, 0, 3, 3, 8'h04, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_FREE_ID, 0, 0, 0, 8'h03, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_op(OP_SYNC, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0), 1,
                         mk_res(ST_FREE_DONE, 0, 0, 0, 0, FR_NONE, 0)});
        rows.push_back('{mk_op(OP_FREE_ALL, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
        foreach (rows[r])
            offer_beat(rows[r].beat, rows[r].typed, rows[r].want);
        drain_results();

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
                    write_reg(CFG_MAX_RETX, 8'd0);
                    write_reg(CFG_OLDEST, 1);
                end
                1:
                begin
                    write_reg(CFG_INTERVAL, 0);
                    write_reg(CFG_MAX_RETX, 8'd255);
                    write_reg(CFG_OLDEST, 1);
                end
                2:
                begin
                    write_reg(CFG_INTERVAL, $urandom_range(1, 6));
                    write_reg(CFG_MAX_RETX, $urandom_range(0, 5));
                    write_reg(CFG_OLDEST, 0);
                end
                default:
                begin
                    write_reg(CFG_INTERVAL, 0);
                    write_reg(CFG_MAX_RETX, $urandom_range(1, 254));
                    write_reg(CFG_OLDEST, $urandom_range(0, 1));
                end
            endcase
            no_idle = (ph == 3);
            for (k = 0; k < 160; k++)
            begin
                // long receiver hold-off while the sender keeps pushing
                if (ph == 1 && k == 20)
                    hold_long = 1;
                // let the pipe empty once mid-phase
                if (ph == 2 && k == 80)
                    drain_results();
                tick = ($urandom_range(0, 15) == 0) ? $urandom : tick + $urandom_range(0, 8);
                pick = $urandom_range(0, 99);
                m = mk_op(OP_SERVICE, tick, 16'($urandom), 16'($urandom),
                          8'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                          3'($urandom), 1'($urandom_range(0, 1)));
                if (pick < 36)      m.op = OP_ADD;
                else if (pick < 76) m.op = OP_SERVICE;
                else if (pick < 84) m.op = OP_FREE_ID;
                else if (pick < 91) m.op = OP_FREE_IDX;
                else if (pick < 94) m.op = OP_FREE_ALL;
                else if (pick < 98) m.op = OP_SYNC;
                else                m.op = 3'($urandom_range(6, 7));
                offer_beat(m, 0, '0);
            end
            drain_results();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
